// ===== rtl/cst_pkg.sv =====
// ---------------------------------------------------------------------------
// cst_pkg
// Shared types, codes and keyword tables for the command script tokenizer.
// ---------------------------------------------------------------------------
package cst_pkg;

  localparam int POS_OUT_W       = 16;
  localparam int KW_COUNT        = 9;
  localparam int KW_TEXT_LEN     = 10;
  localparam int LONGEST_KEYWORD = 10;
  localparam int QUEUE_DEPTH     = 4;
  localparam int QUEUE_PTR_W     = $clog2(QUEUE_DEPTH);

  // record kinds
  localparam logic [1:0] KIND_VALUE = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // error codes
  localparam logic [1:0] ERR_NONE         = 2'd0;
  localparam logic [1:0] ERR_UNEXPECTED   = 2'd1;
  localparam logic [1:0] ERR_UNTERMINATED = 2'd2;

  // token types
  localparam logic [4:0] TOK_IDENT  = 5'd0;
  localparam logic [4:0] TOK_STRING = 5'd10;
  localparam logic [4:0] TOK_NUMBER = 5'd11;
  localparam logic [4:0] TOK_COLON  = 5'd12;
  localparam logic [4:0] TOK_LBRACK = 5'd13;
  localparam logic [4:0] TOK_RBRACK = 5'd14;
  localparam logic [4:0] TOK_LBRACE = 5'd15;
  localparam logic [4:0] TOK_RBRACE = 5'd16;
  localparam logic [4:0] TOK_EQUALS = 5'd17;
  localparam logic [4:0] TOK_COMMA  = 5'd18;
  localparam logic [4:0] TOK_EOF    = 5'd19;

  // characters
  localparam logic [7:0] CH_NUL       = 8'h00;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_HASH      = 8'h23;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_LOWER_N   = 8'h6E;

  localparam logic [8*KW_TEXT_LEN-1:0] KW_STR [KW_COUNT] = '{
    "command", "target", "wsl", "powershell", "params",
    "timeout", "mode", "safe", "raw"
  };
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd7, 4'd6, 4'd3, 4'd10, 4'd6, 4'd7, 4'd4, 4'd4, 4'd3
  };

  typedef struct packed {
    logic [1:0]           kind;
    logic [4:0]           ttype;
    logic [7:0]           value;
    logic [POS_OUT_W-1:0] line;
    logic [POS_OUT_W-1:0] col;
    logic [1:0]           err;
  } rec_t;

  typedef struct packed {
    logic two;
    rec_t rec0;
    rec_t rec1;
  } pkt_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic rec_t make_rec(input logic [1:0] kind, input logic [4:0] ttype,
                                    input logic [7:0] value,
                                    input logic [POS_OUT_W-1:0] line,
                                    input logic [POS_OUT_W-1:0] col,
                                    input logic [1:0] err);
    rec_t r;
    r.kind  = kind;
    r.ttype = ttype;
    r.value = value;
    r.line  = line;
    r.col   = col;
    r.err   = err;
    return r;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || c == 8'h5F;
  endfunction

  function automatic logic [4:0] punct_type(input logic [7:0] c);
    logic [4:0] t;
    case (c)
      8'h3A:   t = TOK_COLON;
      8'h5B:   t = TOK_LBRACK;
      8'h5D:   t = TOK_RBRACK;
      8'h7B:   t = TOK_LBRACE;
      8'h7D:   t = TOK_RBRACE;
      8'h3D:   t = TOK_EQUALS;
      8'h2C:   t = TOK_COMMA;
      default: t = TOK_IDENT;
    endcase
    return t;
  endfunction

  function automatic logic [7:0] kw_char(input int k, input logic [3:0] pos);
    logic [3:0] idx;
    idx = KW_LEN[k] - pos - 4'd1;
    if (pos >= KW_LEN[k]) return 8'h00;
    return KW_STR[k][{idx, 3'b000} +: 8];
  endfunction

  function automatic logic [KW_COUNT-1:0] match_flags(input logic [KW_COUNT-1:0] flags,
                                                      input logic [3:0] wl,
                                                      input logic [7:0] c);
    logic [KW_COUNT-1:0] f;
    f = flags;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (!(wl < 4'(LONGEST_KEYWORD) && wl < KW_LEN[k] && kw_char(k, wl) == c)) begin
        f[k] = 1'b0;
      end
    end
    return f;
  endfunction

  function automatic logic [4:0] word_type(input logic [KW_COUNT-1:0] flags,
                                           input logic [3:0] wl);
    logic [4:0] t;
    t = TOK_IDENT;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (flags[k] && wl == KW_LEN[k]) t = 5'(k + 1);
    end
    return t;
  endfunction

endpackage

// ===== rtl/cst_front.sv =====
// ---------------------------------------------------------------------------
// cst_front
// Lexer front end: takes one request a cycle while the queue has room,
// updates lexer state, packs any one or two records into a queue entry.
// ---------------------------------------------------------------------------
module cst_front #(
  parameter int POSITION_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               action,
  input  logic [7:0]         source_byte,
  input  cst_pkg::q_status_t q_status,
  output logic               push,
  output cst_pkg::pkt_t      pkt
);

  typedef enum logic [2:0] {
    M_IDLE, M_WORD, M_NUMBER, M_STRING, M_ESCAPE, M_COMMENT, M_HALT
  } mode_t;

  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
  localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

  mode_t                          mode, mode_next;
  logic [POSITION_BITS-1:0]       line, line_next;
  logic [POSITION_BITS-1:0]       col, col_next;
  logic [POSITION_BITS-1:0]       start, start_next;
  logic [cst_pkg::KW_COUNT-1:0]   flags, flags_next;
  logic [3:0]                     wl, wl_next;

  logic                           accept;
  logic [7:0]                     c;
  logic                           is_end;
  logic [POSITION_BITS-1:0]       adv_line, adv_col;
  logic [cst_pkg::POS_OUT_W-1:0]  line_o, col_o, start_o;
  logic                           pre_v, idl_v, run_idle;
  cst_pkg::rec_t                  pre, idl;
  logic [cst_pkg::KW_COUNT-1:0]   f_tmp;
  logic [3:0]                     wl_tmp;
  logic [4:0]                     pt;

  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;
  assign c        = source_byte;
  assign is_end   = action || (c == cst_pkg::CH_NUL);
  assign line_o   = cst_pkg::POS_OUT_W'(line);
  assign col_o    = cst_pkg::POS_OUT_W'(col);
  assign start_o  = cst_pkg::POS_OUT_W'(start);
  assign pt       = cst_pkg::punct_type(c);

  // position after the current byte
  always_comb begin
    adv_line = line;
    adv_col  = col;
    if (c == cst_pkg::CH_NEWLINE) begin
      if (line != POS_MAX) adv_line = line + POS_ONE;
      adv_col = POS_ONE;
    end else if (col != POS_MAX) begin
      adv_col = col + POS_ONE;
    end
  end

  always_comb begin
    mode_next  = mode;
    line_next  = line;
    col_next   = col;
    start_next = start;
    flags_next = flags;
    wl_next    = wl;
    pre_v      = 1'b0;
    idl_v      = 1'b0;
    run_idle   = 1'b0;
    pre        = '0;
    idl        = '0;
    f_tmp      = '0;
    wl_tmp     = '0;

    case (mode)
      M_WORD, M_NUMBER: begin
        if (!is_end && (mode == M_WORD ? cst_pkg::is_word(c) : cst_pkg::is_digit(c))) begin
          pre_v = 1'b1;
          if (mode == M_WORD) begin
            f_tmp      = cst_pkg::match_flags(flags, wl, c);
            wl_tmp     = (wl == 4'hF) ? wl : wl + 4'd1;
            flags_next = f_tmp;
            wl_next    = wl_tmp;
            pre = cst_pkg::make_rec(cst_pkg::KIND_VALUE, cst_pkg::word_type(f_tmp, wl_tmp),
                                    c, line_o, col_o, cst_pkg::ERR_NONE);
          end else begin
            pre = cst_pkg::make_rec(cst_pkg::KIND_VALUE, cst_pkg::TOK_NUMBER,
                                    c, line_o, col_o, cst_pkg::ERR_NONE);
          end
          line_next = adv_line;
          col_next  = adv_col;
        end else begin
          pre_v = 1'b1;
          pre = cst_pkg::make_rec(cst_pkg::KIND_DONE,
                                  mode == M_WORD ? cst_pkg::word_type(flags, wl)
                                                 : cst_pkg::TOK_NUMBER,
                                  8'h00, line_o, start_o, cst_pkg::ERR_NONE);
          mode_next = M_IDLE;
          run_idle  = 1'b1;
        end
      end
      M_STRING, M_ESCAPE: begin
        if (is_end) begin
          pre_v = 1'b1;
          pre = cst_pkg::make_rec(cst_pkg::KIND_ERROR, cst_pkg::TOK_IDENT, 8'h00,
                                  line_o, start_o, cst_pkg::ERR_UNTERMINATED);
          mode_next = M_HALT;
        end else if (mode == M_ESCAPE) begin
          pre_v = 1'b1;
          pre = cst_pkg::make_rec(cst_pkg::KIND_VALUE, cst_pkg::TOK_STRING,
                                  c == cst_pkg::CH_LOWER_N ? cst_pkg::CH_NEWLINE : c,
                                  line_o, col_o, cst_pkg::ERR_NONE);
          line_next = adv_line;
          col_next  = adv_col;
          mode_next = M_STRING;
        end else if (c == cst_pkg::CH_QUOTE) begin
          pre_v = 1'b1;
          pre = cst_pkg::make_rec(cst_pkg::KIND_DONE, cst_pkg::TOK_STRING, 8'h00,
                                  cst_pkg::POS_OUT_W'(adv_line), start_o,
                                  cst_pkg::ERR_NONE);
          line_next = adv_line;
          col_next  = adv_col;
          mode_next = M_IDLE;
        end else if (c == cst_pkg::CH_BACKSLASH) begin
          line_next = adv_line;
          col_next  = adv_col;
          mode_next = M_ESCAPE;
        end else begin
          pre_v = 1'b1;
          pre = cst_pkg::make_rec(cst_pkg::KIND_VALUE, cst_pkg::TOK_STRING, c,
                                  line_o, col_o, cst_pkg::ERR_NONE);
          line_next = adv_line;
          col_next  = adv_col;
        end
      end
      M_COMMENT: begin
        if (!is_end && c != cst_pkg::CH_NEWLINE) begin
          line_next = adv_line;
          col_next  = adv_col;
        end else begin
          mode_next = M_IDLE;
          run_idle  = 1'b1;
        end
      end
      M_IDLE: begin
        run_idle = 1'b1;
      end
      default: begin
        mode_next = mode;
      end
    endcase

    if (run_idle) begin
      if (is_end) begin
        idl_v = 1'b1;
        idl = cst_pkg::make_rec(cst_pkg::KIND_DONE, cst_pkg::TOK_EOF, 8'h00,
                                line_o, col_o, cst_pkg::ERR_NONE);
        mode_next = M_HALT;
      end else if (cst_pkg::is_space(c)) begin
        line_next = adv_line;
        col_next  = adv_col;
      end else if (c == cst_pkg::CH_HASH) begin
        line_next = adv_line;
        col_next  = adv_col;
        mode_next = M_COMMENT;
      end else if (cst_pkg::is_alpha(c) || c == 8'h5F) begin
        f_tmp      = cst_pkg::match_flags({cst_pkg::KW_COUNT{1'b1}}, 4'd0, c);
        wl_tmp     = 4'd1;
        flags_next = f_tmp;
        wl_next    = wl_tmp;
        start_next = col;
        idl_v = 1'b1;
        idl = cst_pkg::make_rec(cst_pkg::KIND_VALUE, cst_pkg::word_type(f_tmp, wl_tmp), c,
                                line_o, col_o, cst_pkg::ERR_NONE);
        line_next = adv_line;
        col_next  = adv_col;
        mode_next = M_WORD;
      end else if (cst_pkg::is_digit(c)) begin
        start_next = col;
        idl_v = 1'b1;
        idl = cst_pkg::make_rec(cst_pkg::KIND_VALUE, cst_pkg::TOK_NUMBER, c,
                                line_o, col_o, cst_pkg::ERR_NONE);
        line_next = adv_line;
        col_next  = adv_col;
        mode_next = M_NUMBER;
      end else if (c == cst_pkg::CH_QUOTE) begin
        start_next = col;
        line_next  = adv_line;
        col_next   = adv_col;
        mode_next  = M_STRING;
      end else if (pt != cst_pkg::TOK_IDENT) begin
        idl_v = 1'b1;
        idl = cst_pkg::make_rec(cst_pkg::KIND_DONE, pt, 8'h00, line_o, col_o,
                                cst_pkg::ERR_NONE);
        line_next = adv_line;
        col_next  = adv_col;
      end else begin
        idl_v = 1'b1;
        idl = cst_pkg::make_rec(cst_pkg::KIND_ERROR, cst_pkg::TOK_IDENT, c, line_o, col_o,
                                cst_pkg::ERR_UNEXPECTED);
        mode_next = M_HALT;
      end
    end
  end

  // pack the records of this request
  always_comb begin
    pkt.two  = pre_v && idl_v;
    pkt.rec0 = pre_v ? pre : idl;
    pkt.rec1 = idl;
    push     = accept && (pre_v || idl_v);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= M_IDLE;
      line  <= POS_ONE;
      col   <= POS_ONE;
      start <= POS_ONE;
      flags <= {cst_pkg::KW_COUNT{1'b1}};
      wl    <= 4'd0;
    end else if (accept) begin
      mode  <= mode_next;
      line  <= line_next;
      col   <= col_next;
      start <= start_next;
      flags <= flags_next;
      wl    <= wl_next;
    end
  end

endmodule

// ===== rtl/cst_queue.sv =====
// ---------------------------------------------------------------------------
// cst_queue
// Short queue of record packets between the lexer front end and the
// output stage.
// ---------------------------------------------------------------------------
module cst_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  cst_pkg::pkt_t      push_data,
  input  logic               pop,
  output cst_pkg::pkt_t      head,
  output cst_pkg::q_status_t q_status
);

  cst_pkg::pkt_t                   entries [cst_pkg::QUEUE_DEPTH];
  logic [cst_pkg::QUEUE_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [cst_pkg::QUEUE_PTR_W:0]   count;

  assign head           = entries[rd_ptr];
  assign q_status.full  = (count == (cst_pkg::QUEUE_PTR_W + 1)'(cst_pkg::QUEUE_DEPTH));
  assign q_status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/cst_back.sv =====
// ---------------------------------------------------------------------------
// cst_back
// Output stage: unpacks each queued packet into one or two records and
// holds them in the output register until taken.
// ---------------------------------------------------------------------------
module cst_back (
  input  logic               clk,
  input  logic               rst,
  input  cst_pkg::q_status_t q_status,
  input  cst_pkg::pkt_t      head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output cst_pkg::rec_t      out_rec,
  output logic               out_last
);

  logic sel;
  logic load;
  logic head_last;

  assign load      = !q_status.empty && (!out_valid || out_ready);
  assign head_last = sel || !head.two;
  assign pop       = load && head_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sel       <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
      sel       <= !head_last;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_rec  <= sel ? head.rec1 : head.rec0;
      out_last <= head_last;
    end
  end

endmodule

// ===== rtl/command_script_tokenizer.sv =====
// ---------------------------------------------------------------------------
// command_script_tokenizer
// Streaming tokenizer for a small command script language: bytes in,
// value, token and error records out.
// ---------------------------------------------------------------------------
//  channel  handshake              payload
//  in       in_valid / in_ready    action, source_byte
//  out      out_valid / out_ready  record_kind, token_type, value_byte,
//                                  line_number, column_number, error_code,
//                                  last_of_run
//
//  one request is taken per cycle while the four-entry packet queue has room
//  a request's records pass through the packet queue, then the output
//  register; a request with two records shows them in turn, one with none
//  uses no output cycle, so records leave at one per cycle at most
//  reset clears the lexer mode, positions, queue and output valid flag
//  a stalled output fills the queue, then in_ready falls
module command_script_tokenizer #(
  parameter int POSITION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [7:0]  source_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  record_kind,
  output logic [4:0]  token_type,
  output logic [7:0]  value_byte,
  output logic [15:0] line_number,
  output logic [15:0] column_number,
  output logic [1:0]  error_code,
  output logic        last_of_run
);

  cst_pkg::q_status_t q_status;
  cst_pkg::pkt_t      pkt, head;
  cst_pkg::rec_t      out_rec;
  logic               push, pop;

  cst_front #(
    .POSITION_BITS(POSITION_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .action     (action),
    .source_byte(source_byte),
    .q_status   (q_status),
    .push       (push),
    .pkt        (pkt)
  );

  cst_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(pkt),
    .pop      (pop),
    .head     (head),
    .q_status (q_status)
  );

  cst_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_status (q_status),
    .head     (head),
    .pop      (pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_rec  (out_rec),
    .out_last (last_of_run)
  );

  assign record_kind   = out_rec.kind;
  assign token_type    = out_rec.ttype;
  assign value_byte    = out_rec.value;
  assign line_number   = out_rec.line;
  assign column_number = out_rec.col;
  assign error_code    = out_rec.err;

  // end of file or an error halts the lexer
  a_halt_silent: assert property (@(posedge clk) disable iff (rst)
    push && ((pkt.two ? pkt.rec1.kind : pkt.rec0.kind) == cst_pkg::KIND_ERROR ||
             (pkt.two ? pkt.rec1.ttype : pkt.rec0.ttype) == cst_pkg::TOK_EOF)
    |=> !push)
    else $error("records pushed after end of file or error");

  // second record of a request follows at once
  a_pair_back_to_back: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_of_run |=> out_valid)
    else $error("second record of a request not ready");

  // nothing shows at the output without a queued packet
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    q_status.empty && !out_valid |=> !out_valid)
    else $error("record produced from an empty queue");

endmodule
